// ===== sv/mi_pkg.sv =====
// Shared constants and controller/datapath interface types for the modular inverse block.
package mi_pkg;

  // Default internal word width and the modulus value after reset
  localparam int          MI_WIDTH  = 32;
  localparam logic [31:0] MOD_RESET = 32'h7FFF_FFFF;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;         // latch modulus and value, clear the remainder and r, rr, t
    logic div_step;     // one restoring-division step
    logic mul_step;     // one Horner step of q*tt mod p
    logic reduce;       // divide by the modulus instead of rr
    logic init;         // set up r, rr, t, tt after value mod p
    logic start_round;  // set up the divider and accumulator for a new round
    logic update;       // commit the round: shift remainders and coefficients
    logic out_load;     // capture the result into the output register
  } mi_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic p_zero;       // configured modulus is zero
    logic rr_zero;      // current remainder is zero, loop ends
  } mi_stat_t;

endpackage

// ===== sv/mi_ctrl.sv =====
// Sequencer for the reduction, the Euclid rounds and the result hand-off.
module mi_ctrl #(
  parameter int WIDTH = mi_pkg::MI_WIDTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  mi_pkg::mi_stat_t stat,
  output mi_pkg::mi_cmd_t  cmd
);
  import mi_pkg::*;

  localparam int CW = $clog2(WIDTH + 1);
  localparam logic [CW-1:0] LAST = CW'(WIDTH - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RED  = 3'd1;
  localparam logic [2:0] S_INIT = 3'd2;
  localparam logic [2:0] S_CHK  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_TAIL = 3'd5;
  localparam logic [2:0] S_UPD  = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          in_xfer;

  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  // State sequencing and command decode
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = stat.p_zero ? S_CHK : S_RED;
        end
      end
      S_RED: begin
        cmd.div_step = 1'b1;
        cmd.reduce   = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == LAST) state_nxt = S_INIT;
      end
      S_INIT: begin
        cmd.init  = 1'b1;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (stat.rr_zero) begin
          state_nxt = S_DONE;
        end else begin
          cmd.start_round = 1'b1;
          cnt_nxt         = '0;
          state_nxt       = S_DIV;
        end
      end
      S_DIV: begin
        // multiply trails the divider by one quotient bit
        cmd.div_step = 1'b1;
        cmd.mul_step = (cnt_r != '0);
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == LAST) state_nxt = S_TAIL;
      end
      S_TAIL: begin
        cmd.mul_step = 1'b1;
        state_nxt    = S_UPD;
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_nxt  = S_CHK;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Output slot: filled on load, emptied on transfer
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.out_load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== sv/mi_dpath.sv =====
// Euclid registers, serial divider, serial modular multiplier and output register.
module mi_dpath #(
  parameter int WIDTH = mi_pkg::MI_WIDTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [31:0]      cfg_wdata,
  input  logic [31:0]      in_value,
  output logic [31:0]      out_inverse,
  output logic             out_no_inverse,
  input  mi_pkg::mi_cmd_t  cmd,
  output mi_pkg::mi_stat_t stat
);
  import mi_pkg::*;

  logic [31:0]      modulus_r;
  logic [WIDTH-1:0] p_r, r_r, rr_r, t_r, tt_r;
  logic [WIDTH-1:0] rem_r, dvd_r, acc_r;
  logic             qbit_r;
  logic [31:0]      inv_r;
  logic             noinv_r;

  logic [63:0]      mod_ext, val_ext, t_ext;
  logic [WIDTH-1:0] p_in, v_in, dsr;
  logic [WIDTH:0]   trial, diff;
  logic             ge;
  logic [WIDTH-1:0] rem_step, dvd_step;
  logic [WIDTH+1:0] s, s1, s2, pe;
  logic [WIDTH-1:0] acc_step, nt, tt_init;

  // Operands cut or widened to the internal word
  assign mod_ext = {32'b0, modulus_r};
  assign val_ext = {32'b0, in_value};
  assign p_in    = mod_ext[WIDTH-1:0];
  assign v_in    = val_ext[WIDTH-1:0];

  assign stat.p_zero  = (p_in == '0);
  assign stat.rr_zero = (rr_r == '0);

  // Restoring division step, quotient bits shift into the dividend register
  assign dsr      = cmd.reduce ? p_r : rr_r;
  assign trial    = {rem_r, dvd_r[WIDTH-1]};
  assign diff     = trial - {1'b0, dsr};
  assign ge       = !diff[WIDTH];
  assign rem_step = ge ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
  assign dvd_step = {dvd_r[WIDTH-2:0], ge};

  // Horner step: acc = (2*acc + qbit*tt) mod p, sum stays below 3p
  assign pe       = {2'b0, p_r};
  assign s        = {1'b0, acc_r, 1'b0} + (qbit_r ? {2'b0, tt_r} : '0);
  assign s1       = s - pe;
  assign s2       = s - {pe[WIDTH:0], 1'b0};
  always_comb begin
    if (!s2[WIDTH+1])      acc_step = s2[WIDTH-1:0];
    else if (!s1[WIDTH+1]) acc_step = s1[WIDTH-1:0];
    else                   acc_step = s[WIDTH-1:0];
  end

  // New coefficient t - q*tt mod p
  assign nt      = (t_r >= acc_r) ? (t_r - acc_r) : (t_r - acc_r + p_r);
  assign tt_init = (p_r == WIDTH'(1)) ? '0 : WIDTH'(1);

  // Modulus register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= MOD_RESET;
    end else if (cfg_we) begin
      modulus_r <= cfg_wdata;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      p_r   <= p_in;
      dvd_r <= v_in;
      rem_r <= '0;
      r_r   <= '0;
      rr_r  <= '0;
      t_r   <= '0;
    end
    if (cmd.div_step) begin
      rem_r  <= rem_step;
      dvd_r  <= dvd_step;
      qbit_r <= ge;
    end
    if (cmd.mul_step) acc_r <= acc_step;
    if (cmd.init) begin
      r_r  <= p_r;
      rr_r <= rem_r;
      t_r  <= '0;
      tt_r <= tt_init;
    end
    if (cmd.start_round) begin
      dvd_r <= r_r;
      rem_r <= '0;
      acc_r <= '0;
    end
    if (cmd.update) begin
      r_r  <= rr_r;
      rr_r <= rem_r;
      t_r  <= tt_r;
      tt_r <= nt;
    end
  end

  // Result register
  assign t_ext = 64'(t_r);
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      inv_r   <= t_ext[31:0];
      noinv_r <= (r_r != WIDTH'(1));
    end
  end

  assign out_inverse    = inv_r;
  assign out_no_inverse = noinv_r;

endmodule

// ===== sv/modular_inverse.sv =====
// Top level of the modular inverse block: controller plus datapath.
// Computes value^-1 mod modulus by the extended Euclidean algorithm, one item
// at a time. The value is first reduced by a bit-serial divider, then in each
// Euclid round the same divider yields the quotient one bit a cycle while a
// trailing shift-add unit forms q*tt mod p.
// The result waits in an output register, so the next item can be accepted
// while it is still stalled. A zero modulus returns inverse 0 with the flag set.
module modular_inverse #(
  parameter int WIDTH = mi_pkg::MI_WIDTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_inverse,
  output logic        out_no_inverse
);
  import mi_pkg::*;

  mi_cmd_t  cmd;
  mi_stat_t stat;

  mi_ctrl #(.WIDTH(WIDTH)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  mi_dpath #(.WIDTH(WIDTH)) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_value       (in_value),
    .out_inverse    (out_inverse),
    .out_no_inverse (out_no_inverse),
    .cmd            (cmd),
    .stat           (stat)
  );

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for the modular inverse block with an inverse scoreboard.
module testbench;

  localparam int CLK_HALF     = 6;
  localparam int HOLD_CYCLES  = 6000;
  localparam int LIMIT_CYCLES = 4_000_000;
  localparam int MAX_GAP      = 18;
  localparam int PHASE_ITEMS  = 50;
  localparam int REPORT_MAX   = 10;

  // Expected contents of one result transfer
  typedef struct packed {
    logic [31:0] inverse;
    logic        no_inverse;
  } inverse_t;

  // Scoreboard: predicts the inverse of each accepted value, checks results in order
  class inverse_board;
    logic [31:0] modulus = mi_pkg::MOD_RESET;
    inverse_t    due_q[$];
    int          faults = 0;

    function void flag_fault(string msg);
      faults++;
      if (faults <= REPORT_MAX) $display("%s", msg);
    endfunction

    // Extended Euclid on (modulus, value mod modulus), coefficient kept in 0..modulus-1
    function inverse_t predict_inverse(logic [31:0] value);
      logic [63:0] p, r, rr, t, tt, q, nr, prod, nt;
      inverse_t    res;
      p = {32'b0, modulus};
      if (p == 0) begin
        res.inverse    = '0;
        res.no_inverse = 1'b1;
        return res;
      end
      r  = p;
      rr = {32'b0, value} % p;
      t  = 0;
      tt = 64'd1 % p;
      while (rr != 0) begin
        q    = r / rr;
        nr   = r - q * rr;
        prod = ((q % p) * tt) % p;
        nt   = (t >= prod) ? (t - prod) : (t + (p - prod));
        r    = rr;
        rr   = nr;
        t    = tt;
        tt   = nt;
      end
      t              = t % p;
      res.inverse    = t[31:0];
      res.no_inverse = (r != 1);
      return res;
    endfunction

    function void note_value(logic [31:0] value);
      due_q.push_back(predict_inverse(value));
    endfunction

    function void check_result(logic [31:0] inverse, logic no_inverse);
      inverse_t want;
      if (due_q.size() == 0) begin
        flag_fault($sformatf("unexpected result: inverse=%h no_inverse=%b",
                             inverse, no_inverse));
        return;
      end
      want = due_q.pop_front();
      if (inverse !== want.inverse)
        flag_fault($sformatf("inverse mismatch (modulus %h): expected %h, got %h",
                             modulus, want.inverse, inverse));
      if (no_inverse !== want.no_inverse)
        flag_fault($sformatf("no_inverse mismatch (modulus %h): expected %b, got %b",
                             modulus, want.no_inverse, no_inverse));
    endfunction

    function int pending();
      return due_q.size();
    endfunction

    function void close();
      if (due_q.size() != 0)
        flag_fault($sformatf("%0d results never arrived", due_q.size()));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_inverse;
  logic        out_no_inverse;

  inverse_board board = new;
  bit           hold_req = 1'b0;
  bit           tx_quiet = 1'b0;
  int           tx_left = 0;
  int unsigned  cycles = 0;

  modular_inverse u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_inverse   (out_inverse),
    .out_no_inverse(out_no_inverse)
  );

  always #CLK_HALF clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Transfer monitor on both channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) board.note_value(in_value);
      if (out_valid && !out_stall) board.check_result(out_inverse, out_no_inverse);
    end
  end

  // Result receiver: random stalls, quiet runs, and one long hold-off on request
  initial begin : receiver
    int n;
    int rx_left;
    bit rx_quiet;
    rx_left  = 0;
    rx_quiet = 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (rx_left == 0) begin
        rx_left  = $urandom_range(4, 30);
        rx_quiet = ($urandom_range(0, 2) == 0);
      end
      rx_left--;
      n = rx_quiet ? 0 : $urandom_range(0, MAX_GAP);
      if (n != 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // Offer one value after a random gap and wait for its transfer; called at a falling edge
  task automatic send_value(logic [31:0] value);
    int gap;
    if (tx_left == 0) begin
      tx_left  = $urandom_range(3, 25);
      tx_quiet = ($urandom_range(0, 2) == 0);
    end
    tx_left--;
    gap = tx_quiet ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_value <= value;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Stop offering and wait until every outstanding result has been taken
  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(negedge clk);
  endtask

  // Modulus is only written with the block idle
  task automatic set_modulus(logic [31:0] m);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(negedge clk);
    cfg_we <= 1'b0;
    board.modulus = m;
  endtask

  // Mix of full-range values, values below the modulus, and edges near 0 and the modulus
  function automatic logic [31:0] pick_value(logic [31:0] p);
    logic [31:0] v;
    case ($urandom_range(0, 5))
      0: v = $urandom;
      1: v = (p == 0) ? $urandom : $urandom_range(0, p - 1);
      2: v = $urandom_range(0, 16);
      3: v = p - $urandom_range(0, 3);
      4: v = p * $urandom_range(0, 3);
      default: v = $urandom & ($urandom >> $urandom_range(0, 31));
    endcase
    return v;
  endfunction

  initial begin : stimulus
    logic [31:0] phase_mod [8];
    logic [31:0] m;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: reset modulus, extremes, multiples and values above the modulus
    send_value(32'd0);
    send_value(32'd1);
    send_value(32'd2);
    send_value(32'h7FFF_FFFE);
    send_value(32'h7FFF_FFFF);
    send_value(32'h8000_0000);
    send_value(32'hFFFF_FFFF);
    send_value(32'hFFFF_FFFE);
    send_value(32'h1234_5678);
    // consecutive Fibonacci numbers: the longest Euclid run at 32 bits
    set_modulus(32'd2971215073);
    send_value(32'd1836311903);
    // composite modulus: coprime and not coprime cases
    set_modulus(32'd12);
    send_value(32'd5);
    send_value(32'd8);
    send_value(32'd6);
    send_value(32'd13);
    // modulus one: everything reduces to zero, flag clear
    set_modulus(32'd1);
    send_value(32'd0);
    send_value(32'hFFFF_FFFF);
    // modulus zero: flag set
    set_modulus(32'd0);
    send_value(32'd0);
    send_value(32'h5A5A_5A5A);
    set_modulus(32'd2);
    send_value(32'd1);
    send_value(32'd3);
    send_value(32'd4);
    set_modulus(32'hFFFF_FFFF);
    send_value(32'hFFFF_FFFE);
    send_value(32'h0001_0000);
    send_value(32'd255);

    // Random phases over several moduli
    phase_mod = '{32'hFFFF_FFFB, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd2,
                  32'd65521, $urandom, $urandom_range(3, 1000), 32'h8000_0000};
    for (int ph = 0; ph < 8; ph++) begin
      m = phase_mod[ph];
      set_modulus(m);
      // second phase: receiver holds off while values keep coming
      if (ph == 1) begin
        hold_req = 1'b1;
        tx_quiet = 1'b1;
        tx_left  = 8;
      end
      repeat (PHASE_ITEMS) send_value(pick_value(m));
    end

    drain();
    repeat (2000) @(negedge clk);
    board.close();
    if (board.faults == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
